>>> hw/rtl/hsd_pkg.sv
// Shared constants for the header-synchronized packet deframer.
`timescale 1ns / 1ps

package hsd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int PAYLOAD_LEN  = 16;
    localparam int STORE_DEPTH  = PAYLOAD_LEN - 1;
    localparam int PACKET_LEN   = HEADER_BYTES + PAYLOAD_LEN;

    localparam int POS_W   = $clog2(PACKET_LEN);
    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int HSEL_W  = $clog2(HEADER_BYTES > 1 ? HEADER_BYTES : 2);

    localparam logic [63:0]      HEADER_RESET = 64'h3938_3736_3534_3332;
    localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PACKET_LEN - 1);

    typedef logic [7:0] t_byte;

endpackage

>>> hw/rtl/header_sync_packet_deframer.sv
// Header-synchronized fixed-length packet deframer: top level.
`timescale 1ns / 1ps

// Takes one received byte per transfer and accepts one in every cycle but for the stall below.
// The first eight bytes of a packet must match the header pattern register
// (first byte in bits 7:0); a mismatching byte is dropped and the search
// restarts at the next byte. The following 16 bytes are payload. The transfer
// of the 24th byte produces one result, registered in the following cycle:
// four little-endian 32-bit words and the loop time given with that byte. Header
// and payload bytes never wait on the output side; only the final byte of a
// packet stalls, and only while the previous result is still held by a stall
// at the output register. Write the header register only while idle.
module header_sync_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_header_pattern_we,
    input  logic [63:0] i_header_pattern,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_loop_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_yaw_bits,
    output logic [31:0] o_pitch_bits,
    output logic [31:0] o_roll_bits,
    output logic [31:0] o_thrust_bits,
    output logic [31:0] o_packet_time
);

    logic [63:0]                r_header;
    logic [hsd_pkg::POS_W-1:0]  r_pos;
    logic [hsd_pkg::POS_W-1:0]  n_pos;
    hsd_pkg::t_byte             r_store [hsd_pkg::STORE_DEPTH];
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [31:0]                r_yaw;
    logic [31:0]                r_pitch;
    logic [31:0]                r_roll;
    logic [31:0]                r_thrust;
    logic [31:0]                r_time;

    logic                       in_xfer;
    logic                       in_header;
    logic                       is_last;
    logic                       emit;
    hsd_pkg::t_byte             want;
    logic [hsd_pkg::POS_W-1:0]  store_off;
    logic [hsd_pkg::IDX_W-1:0]  store_idx;

    assign in_header = (r_pos < hsd_pkg::POS_HDR_END);
    assign is_last   = (r_pos >= hsd_pkg::POS_LAST);
    // Only a completing byte needs room in the output register.
    assign o_in_stall = is_last && r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign emit       = in_xfer && is_last;

    assign want      = r_header[r_pos[hsd_pkg::HSEL_W-1:0] * 8 +: 8];
    assign store_off = r_pos - hsd_pkg::POS_HDR_END;
    assign store_idx = store_off[hsd_pkg::IDX_W-1:0];

    always_comb begin
        n_pos = r_pos;
        if (in_xfer) begin
            if (in_header) begin
                n_pos = (i_rx_byte == want) ? r_pos + 1'b1 : '0;
            end else if (is_last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= hsd_pkg::HEADER_RESET;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_header_pattern_we) begin
                r_header <= i_header_pattern;
            end
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload store and result register: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xfer && !in_header && !is_last) begin
            r_store[store_idx] <= i_rx_byte;
        end
        if (emit) begin
            r_yaw    <= {r_store[3], r_store[2], r_store[1], r_store[0]};
            r_pitch  <= {r_store[7], r_store[6], r_store[5], r_store[4]};
            r_roll   <= {r_store[11], r_store[10], r_store[9], r_store[8]};
            r_thrust <= {i_rx_byte, r_store[14], r_store[13], r_store[12]};
            r_time   <= i_loop_time;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_yaw_bits    = r_yaw;
    assign o_pitch_bits  = r_pitch;
    assign o_roll_bits   = r_roll;
    assign o_thrust_bits = r_thrust;
    assign o_packet_time = r_time;

endmodule

>>> hw/rtl/hsd_checker.sv
// Port-level checker for the packet deframer, bound to the top level.
`timescale 1ns / 1ps

module hsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_header_pattern_we,
    input  logic [63:0] i_header_pattern,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_loop_time,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] o_yaw_bits,
    input  logic [31:0] o_pitch_bits,
    input  logic [31:0] o_roll_bits,
    input  logic [31:0] o_thrust_bits,
    input  logic [31:0] o_packet_time
);

    // A held result stays valid and unchanged.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_yaw_bits) && $stable(o_pitch_bits)
            && $stable(o_roll_bits) && $stable(o_thrust_bits) && $stable(o_packet_time))
        else $error("result changed while stalled");

    // Input backpressure only arises from a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A fresh result must follow an input transfer.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!$past(o_out_valid) || !$past(i_out_stall))
            |-> $past(i_in_valid && !o_in_stall))
        else $error("result without an input transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind header_sync_packet_deframer hsd_checker u_hsd_checker (.*);
